FILE: design/assert_macros.svh
// Assertion shorthands shared by the radio link event queue RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RLSEQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlseq: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RLSEQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlseq: next-cycle check failed");

`endif

FILE: design/rlseq_pkg.sv
// Shared types and codes for the radio link state and event queue block.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rlseq_pkg;

  localparam int CMD_W    = 4;
  localparam int STATUS_W = 3;
  localparam int LINK_W   = 3;
  localparam int EV_W     = 3;
  localparam int PEER_W   = 48;
  localparam int LEN_W    = 16;
  localparam int IRQ_W    = 8;
  localparam int EVLEN_W  = 8;
  localparam int ENTRY_W  = EV_W + PEER_W;
  localparam int PUSH_W   = 6;

  localparam int IRQ_CONNECTED    = 0;
  localparam int IRQ_DISCONNECTED = 1;
  localparam int IRQ_RX_DONE      = 2;
  localparam int IRQ_TX_DONE      = 3;
  localparam int IRQ_ERROR        = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT       = 4'd0,
    CMD_DEINIT     = 4'd1,
    CMD_ADV_START  = 4'd2,
    CMD_ADV_STOP   = 4'd3,
    CMD_SCAN_START = 4'd4,
    CMD_SCAN_STOP  = 4'd5,
    CMD_CONNECT    = 4'd6,
    CMD_DISCONNECT = 4'd7,
    CMD_SEND       = 4'd8,
    CMD_INTERRUPT  = 4'd9,
    CMD_PROCESS    = 4'd10
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_NOT_READY = 3'd2,
    ST_BUSY      = 3'd3,
    ST_TIMEOUT   = 3'd4
  } status_code_t;

  typedef enum logic [LINK_W-1:0] {
    LS_OFF           = 3'd0,
    LS_IDLE          = 3'd1,
    LS_ADV           = 3'd2,
    LS_SCAN          = 3'd3,
    LS_CONNECTING    = 3'd4,
    LS_CONNECTED     = 3'd5,
    LS_DISCONNECTING = 3'd6,
    LS_ERROR         = 3'd7
  } link_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE          = 3'd0,
    EV_ADV_STARTED   = 3'd1,
    EV_ADV_STOPPED   = 3'd2,
    EV_CONNECTED     = 3'd3,
    EV_DISCONNECTED  = 3'd4,
    EV_DATA_SENT     = 3'd5,
    EV_ERROR         = 3'd6,
    EV_DATA_RECEIVED = 3'd7
  } event_t;

  // Pending pushes: bit k-1 stands for event kind k, pushed lowest kind first.
  localparam logic [PUSH_W-1:0] PUSH_ADV_STARTED  = PUSH_W'(1) << (int'(EV_ADV_STARTED) - 1);
  localparam logic [PUSH_W-1:0] PUSH_ADV_STOPPED  = PUSH_W'(1) << (int'(EV_ADV_STOPPED) - 1);
  localparam logic [PUSH_W-1:0] PUSH_CONNECTED    = PUSH_W'(1) << (int'(EV_CONNECTED) - 1);
  localparam logic [PUSH_W-1:0] PUSH_DISCONNECTED = PUSH_W'(1) << (int'(EV_DISCONNECTED) - 1);
  localparam logic [PUSH_W-1:0] PUSH_DATA_SENT    = PUSH_W'(1) << (int'(EV_DATA_SENT) - 1);
  localparam logic [PUSH_W-1:0] PUSH_ERROR        = PUSH_W'(1) << (int'(EV_ERROR) - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_EXEC  = 3'd1,
    S_PUSH  = 3'd2,
    S_REPLY = 3'd3,
    S_DRAIN = 3'd4
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic push_step;
    logic reply_load;
    logic drain_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_process;
    logic push_pending;
    logic drain_empty;
    logic drain_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/rlseq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the event ring entries for the datapath.
`timescale 1ns / 1ps
`default_nettype none

module rlseq_ram #(
  parameter int WIDTH = 51,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: design/rlseq_dp.sv
// Datapath: command checks, link state, peer and receive registers, event ring
// and the result register. Uses rlseq_pkg, rlseq_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rlseq_dp #(
  parameter int RING_DEPTH  = 8,
  parameter int MAX_PAYLOAD = 244
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire rlseq_pkg::ctrl_cmd_t            ctrl,
  output rlseq_pkg::dp_stat_t                  stat,
  input  wire logic [rlseq_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic                            in_controller_ready,
  input  wire logic                            in_transmitter_busy,
  input  wire logic [rlseq_pkg::PEER_W-1:0]    in_peer_address,
  input  wire logic [rlseq_pkg::LEN_W-1:0]     in_send_length,
  input  wire logic [rlseq_pkg::IRQ_W-1:0]     in_irq_flags,
  input  wire logic [rlseq_pkg::LEN_W-1:0]     in_received_length,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [rlseq_pkg::STATUS_W-1:0]       out_status,
  output logic [rlseq_pkg::LINK_W-1:0]         out_link_state,
  output logic [rlseq_pkg::EV_W-1:0]           out_event_kind,
  output logic [rlseq_pkg::PEER_W-1:0]         out_event_peer,
  output logic [rlseq_pkg::EVLEN_W-1:0]        out_event_length,
  output logic                                 out_last
);

  localparam int PTR_W = $clog2(RING_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Captured request
  rlseq_pkg::cmd_t                  cmd_r;
  logic                             ready_r;
  logic                             busy_r;
  logic [rlseq_pkg::PEER_W-1:0]     peer_r;
  logic [rlseq_pkg::LEN_W-1:0]      slen_r;
  logic [rlseq_pkg::IRQ_W-1:0]      irq_r;
  logic [rlseq_pkg::LEN_W-1:0]      rlen_r;

  // Block state
  rlseq_pkg::link_t                 link_state_r, link_state_nxt;
  logic                             init_r, init_nxt;
  logic [PTR_W-1:0]                 wp_r, wp_nxt;
  logic [PTR_W-1:0]                 rp_r, rp_nxt;
  logic [rlseq_pkg::PEER_W-1:0]     stored_peer_r, stored_peer_nxt;
  logic                             rx_pend_r, rx_pend_nxt;
  logic [rlseq_pkg::EVLEN_W-1:0]    pend_len_r, pend_len_nxt;
  logic [rlseq_pkg::PUSH_W-1:0]     mask_r, mask_nxt;
  logic [rlseq_pkg::PEER_W-1:0]     push_peer_r, push_peer_nxt;
  rlseq_pkg::status_code_t          status_r, status_nxt;

  // Result register
  logic                             out_valid_r, out_valid_nxt;
  rlseq_pkg::status_code_t          out_status_r, out_status_nxt;
  rlseq_pkg::link_t                 out_link_r, out_link_nxt;
  rlseq_pkg::event_t                out_kind_r, out_kind_nxt;
  logic [rlseq_pkg::PEER_W-1:0]     out_peer_r, out_peer_nxt;
  logic [rlseq_pkg::EVLEN_W-1:0]    out_len_r, out_len_nxt;
  logic                             out_last_r, out_last_nxt;

  // Execute decode
  rlseq_pkg::status_code_t          ex_status;
  rlseq_pkg::link_t                 ex_link;
  logic                             ex_init;
  logic                             ex_clr_ptr;
  logic [rlseq_pkg::PUSH_W-1:0]     ex_mask;
  logic [rlseq_pkg::PEER_W-1:0]     ex_peer;
  logic                             ex_set_peer;
  logic                             ex_rx_set;
  logic [rlseq_pkg::EVLEN_W-1:0]    rx_len_sat;

  // Ring access
  rlseq_pkg::event_t                push_kind;
  logic [rlseq_pkg::PUSH_W-1:0]     push_clr;
  logic                             ring_full;
  logic                             ram_we;
  logic [rlseq_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [rlseq_pkg::ENTRY_W-1:0]    ram_rdata;
  logic                             drain_last;
  logic                             out_free;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r   <= rlseq_pkg::cmd_t'(in_cmd);
      ready_r <= in_controller_ready;
      busy_r  <= in_transmitter_busy;
      peer_r  <= in_peer_address;
      slen_r  <= in_send_length;
      irq_r   <= in_irq_flags;
      rlen_r  <= in_received_length;
    end
  end

  assign rx_len_sat = (rlen_r > rlseq_pkg::LEN_W'(MAX_PAYLOAD)) ?
                      rlseq_pkg::EVLEN_W'(MAX_PAYLOAD) : rlen_r[rlseq_pkg::EVLEN_W-1:0];

  always_comb begin
    ex_status   = rlseq_pkg::ST_OK;
    ex_link     = link_state_r;
    ex_init     = init_r;
    ex_clr_ptr  = 1'b0;
    ex_mask     = '0;
    ex_peer     = '0;
    ex_set_peer = 1'b0;
    ex_rx_set   = 1'b0;
    case (cmd_r)
      rlseq_pkg::CMD_INIT: begin
        if (!ready_r) begin
          ex_status = rlseq_pkg::ST_TIMEOUT;
        end else begin
          ex_link    = rlseq_pkg::LS_IDLE;
          ex_init    = 1'b1;
          ex_clr_ptr = 1'b1;
        end
      end
      rlseq_pkg::CMD_DEINIT: begin
        if (!init_r) begin
          ex_status = rlseq_pkg::ST_NOT_READY;
        end else begin
          ex_link = rlseq_pkg::LS_OFF;
          ex_init = 1'b0;
        end
      end
      rlseq_pkg::CMD_ADV_START: begin
        if (!init_r) begin
          ex_status = rlseq_pkg::ST_NOT_READY;
        end else if (link_state_r != rlseq_pkg::LS_IDLE &&
                     link_state_r != rlseq_pkg::LS_CONNECTED) begin
          ex_status = rlseq_pkg::ST_BUSY;
        end else begin
          ex_link = rlseq_pkg::LS_ADV;
          ex_mask = rlseq_pkg::PUSH_ADV_STARTED;
        end
      end
      rlseq_pkg::CMD_ADV_STOP: begin
        if (!init_r) begin
          ex_status = rlseq_pkg::ST_NOT_READY;
        end else if (link_state_r != rlseq_pkg::LS_ADV) begin
          ex_status = rlseq_pkg::ST_INVALID;
        end else begin
          ex_link = rlseq_pkg::LS_IDLE;
          ex_mask = rlseq_pkg::PUSH_ADV_STOPPED;
        end
      end
      rlseq_pkg::CMD_SCAN_START: begin
        if (!init_r) begin
          ex_status = rlseq_pkg::ST_NOT_READY;
        end else if (link_state_r != rlseq_pkg::LS_IDLE) begin
          ex_status = rlseq_pkg::ST_BUSY;
        end else begin
          ex_link = rlseq_pkg::LS_SCAN;
        end
      end
      rlseq_pkg::CMD_SCAN_STOP: begin
        if (!init_r) begin
          ex_status = rlseq_pkg::ST_NOT_READY;
        end else if (link_state_r != rlseq_pkg::LS_SCAN) begin
          ex_status = rlseq_pkg::ST_INVALID;
        end else begin
          ex_link = rlseq_pkg::LS_IDLE;
        end
      end
      rlseq_pkg::CMD_CONNECT: begin
        if (!init_r) begin
          ex_status = rlseq_pkg::ST_NOT_READY;
        end else if (link_state_r != rlseq_pkg::LS_IDLE &&
                     link_state_r != rlseq_pkg::LS_SCAN) begin
          ex_status = rlseq_pkg::ST_BUSY;
        end else begin
          ex_link     = rlseq_pkg::LS_CONNECTING;
          ex_set_peer = 1'b1;
        end
      end
      rlseq_pkg::CMD_DISCONNECT: begin
        if (!init_r) begin
          ex_status = rlseq_pkg::ST_NOT_READY;
        end else if (link_state_r != rlseq_pkg::LS_CONNECTED) begin
          ex_status = rlseq_pkg::ST_INVALID;
        end else begin
          ex_link = rlseq_pkg::LS_DISCONNECTING;
        end
      end
      rlseq_pkg::CMD_SEND: begin
        if (slen_r > rlseq_pkg::LEN_W'(MAX_PAYLOAD)) begin
          ex_status = rlseq_pkg::ST_INVALID;
        end else if (!init_r || link_state_r != rlseq_pkg::LS_CONNECTED) begin
          ex_status = rlseq_pkg::ST_NOT_READY;
        end else if (busy_r) begin
          ex_status = rlseq_pkg::ST_TIMEOUT;
        end
      end
      rlseq_pkg::CMD_INTERRUPT: begin
        // All events of one interrupt carry the peer once connected is flagged
        if (irq_r[rlseq_pkg::IRQ_CONNECTED]) begin
          ex_link = rlseq_pkg::LS_CONNECTED;
          ex_mask = ex_mask | rlseq_pkg::PUSH_CONNECTED;
          ex_peer = stored_peer_r;
        end
        if (irq_r[rlseq_pkg::IRQ_DISCONNECTED]) begin
          ex_link = rlseq_pkg::LS_IDLE;
          ex_mask = ex_mask | rlseq_pkg::PUSH_DISCONNECTED;
        end
        if (irq_r[rlseq_pkg::IRQ_RX_DONE]) begin
          ex_rx_set = 1'b1;
        end
        if (irq_r[rlseq_pkg::IRQ_TX_DONE]) begin
          ex_mask = ex_mask | rlseq_pkg::PUSH_DATA_SENT;
        end
        if (irq_r[rlseq_pkg::IRQ_ERROR]) begin
          ex_link = rlseq_pkg::LS_ERROR;
          ex_mask = ex_mask | rlseq_pkg::PUSH_ERROR;
        end
      end
      rlseq_pkg::CMD_PROCESS: begin
        ex_status = rlseq_pkg::ST_OK;
      end
      default: begin
        ex_status = rlseq_pkg::ST_INVALID;
      end
    endcase
  end

  // Pick the lowest pending event kind
  always_comb begin
    push_kind = rlseq_pkg::EV_NONE;
    push_clr  = '0;
    for (int i = rlseq_pkg::PUSH_W - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        push_kind = rlseq_pkg::event_t'(rlseq_pkg::EV_W'(i + 1));
        push_clr  = rlseq_pkg::PUSH_W'(1) << i;
      end
    end
  end

  assign ring_full = (ptr_inc(wp_r) == rp_r);
  // Drop the push when the ring is full
  assign ram_we    = ctrl.push_step && (mask_r != '0) && !ring_full;
  assign ram_wdata = {push_kind, push_peer_r};

  assign drain_last = rx_pend_r ? (rp_r == wp_r) : (ptr_inc(rp_r) == wp_r);
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    link_state_nxt  = link_state_r;
    init_nxt        = init_r;
    wp_nxt          = wp_r;
    rp_nxt          = rp_r;
    stored_peer_nxt = stored_peer_r;
    rx_pend_nxt     = rx_pend_r;
    pend_len_nxt    = pend_len_r;
    mask_nxt        = mask_r;
    push_peer_nxt   = push_peer_r;
    status_nxt      = status_r;
    out_status_nxt  = out_status_r;
    out_link_nxt    = out_link_r;
    out_kind_nxt    = out_kind_r;
    out_peer_nxt    = out_peer_r;
    out_len_nxt     = out_len_r;
    out_last_nxt    = out_last_r;
    out_valid_nxt   = out_valid_r && out_stall;

    if (ctrl.execute) begin
      status_nxt     = ex_status;
      link_state_nxt = ex_link;
      init_nxt       = ex_init;
      mask_nxt       = ex_mask;
      push_peer_nxt  = ex_peer;
      if (ex_clr_ptr) begin
        wp_nxt = '0;
        rp_nxt = '0;
      end
      if (ex_set_peer) begin
        stored_peer_nxt = peer_r;
      end
      if (ex_rx_set) begin
        rx_pend_nxt  = 1'b1;
        pend_len_nxt = rx_len_sat;
      end
    end

    if (ctrl.push_step) begin
      mask_nxt = mask_r & ~push_clr;
      if (ram_we) begin
        wp_nxt = ptr_inc(wp_r);
      end
    end

    if (ctrl.reply_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      out_link_nxt   = link_state_r;
      out_kind_nxt   = rlseq_pkg::EV_NONE;
      out_peer_nxt   = '0;
      out_len_nxt    = '0;
      out_last_nxt   = 1'b1;
    end

    if (ctrl.drain_step) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = rlseq_pkg::ST_OK;
      out_link_nxt   = link_state_r;
      out_last_nxt   = drain_last;
      if (rx_pend_r) begin
        rx_pend_nxt  = 1'b0;
        out_kind_nxt = rlseq_pkg::EV_DATA_RECEIVED;
        out_peer_nxt = stored_peer_r;
        out_len_nxt  = pend_len_r;
      end else begin
        out_kind_nxt = rlseq_pkg::event_t'(ram_rdata[rlseq_pkg::ENTRY_W-1 -: rlseq_pkg::EV_W]);
        out_peer_nxt = ram_rdata[rlseq_pkg::PEER_W-1:0];
        out_len_nxt  = '0;
        rp_nxt       = ptr_inc(rp_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_state_r  <= rlseq_pkg::LS_OFF;
      init_r        <= 1'b0;
      wp_r          <= '0;
      rp_r          <= '0;
      stored_peer_r <= '0;
      rx_pend_r     <= 1'b0;
      pend_len_r    <= '0;
      mask_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      link_state_r  <= link_state_nxt;
      init_r        <= init_nxt;
      wp_r          <= wp_nxt;
      rp_r          <= rp_nxt;
      stored_peer_r <= stored_peer_nxt;
      rx_pend_r     <= rx_pend_nxt;
      pend_len_r    <= pend_len_nxt;
      mask_r        <= mask_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    push_peer_r  <= push_peer_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_link_r   <= out_link_nxt;
    out_kind_r   <= out_kind_nxt;
    out_peer_r   <= out_peer_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Read address follows the next read pointer, so the registered read data
  // always shows the oldest entry at the current read pointer.
  rlseq_ram #(
    .WIDTH (rlseq_pkg::ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wp_r),
    .wr_data (ram_wdata),
    .rd_addr (rp_nxt),
    .rd_data (ram_rdata)
  );

  assign stat.is_process   = (cmd_r == rlseq_pkg::CMD_PROCESS);
  assign stat.push_pending = (mask_r != '0);
  assign stat.drain_empty  = !rx_pend_r && (rp_r == wp_r);
  assign stat.drain_last   = drain_last;
  assign stat.out_free     = out_free;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_link_state   = out_link_r;
  assign out_event_kind   = out_kind_r;
  assign out_event_peer   = out_peer_r;
  assign out_event_length = out_len_r;
  assign out_last         = out_last_r;

  `RLSEQ_ASSERT_NXT(a_drain_ends_empty, ctrl.drain_step && drain_last, (rp_r == wp_r) && !rx_pend_r)
  `RLSEQ_ASSERT_IMP(a_no_load_on_stall, out_valid_r && out_stall, !(ctrl.reply_load || ctrl.drain_step))
  `RLSEQ_ASSERT_NXT(a_init_empties, ctrl.execute && (cmd_r == rlseq_pkg::CMD_INIT) && ready_r, (wp_r == '0) && (rp_r == '0))
  `RLSEQ_ASSERT_IMP(a_push_has_work, ctrl.push_step, mask_r != '0)

endmodule

`default_nettype wire

FILE: design/rlseq_ctrl.sv
// Controller: sequences capture, execute, ring pushes and result loads.
// Uses rlseq_pkg; drives the datapath through ctrl_cmd_t only.
`timescale 1ns / 1ps
`default_nettype none

module rlseq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output rlseq_pkg::ctrl_cmd_t      ctrl,
  input  wire rlseq_pkg::dp_stat_t  stat
);

  rlseq_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlseq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_stall  = 1'b1;
    case (state_r)
      rlseq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_nxt    = rlseq_pkg::S_EXEC;
        end
      end
      rlseq_pkg::S_EXEC: begin
        ctrl.execute = 1'b1;
        if (!stat.is_process) begin
          state_nxt = rlseq_pkg::S_PUSH;
        end else if (stat.drain_empty) begin
          state_nxt = rlseq_pkg::S_REPLY;
        end else begin
          state_nxt = rlseq_pkg::S_DRAIN;
        end
      end
      rlseq_pkg::S_PUSH: begin
        // One ring write per cycle
        if (stat.push_pending) begin
          ctrl.push_step = 1'b1;
        end else begin
          state_nxt = rlseq_pkg::S_REPLY;
        end
      end
      rlseq_pkg::S_REPLY: begin
        if (stat.out_free) begin
          ctrl.reply_load = 1'b1;
          state_nxt       = rlseq_pkg::S_IDLE;
        end
      end
      rlseq_pkg::S_DRAIN: begin
        if (stat.out_free) begin
          ctrl.drain_step = 1'b1;
          if (stat.drain_last) begin
            state_nxt = rlseq_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = rlseq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/radio_link_state_event_queue.sv
// A request is captured and executed, then each pending event is written to the
// ring in turn (one for adv start or stop, up to four for an interrupt) before
// the result is loaded; the next request is taken once that result is loaded.
// Process instead drains the ring, one result per cycle while the output is
// not stalled, with out_last on the final one. Stalls hold it all.
// Reset (synchronous, rst_n low): link off, not initialized, ring empty.
`timescale 1ns / 1ps
`default_nettype none

module radio_link_state_event_queue #(
  parameter int RING_DEPTH  = 8,
  parameter int MAX_PAYLOAD = 244
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [rlseq_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic                         in_controller_ready,
  input  wire logic                         in_transmitter_busy,
  input  wire logic [rlseq_pkg::PEER_W-1:0] in_peer_address,
  input  wire logic [rlseq_pkg::LEN_W-1:0]  in_send_length,
  input  wire logic [rlseq_pkg::IRQ_W-1:0]  in_irq_flags,
  input  wire logic [rlseq_pkg::LEN_W-1:0]  in_received_length,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [rlseq_pkg::STATUS_W-1:0]    out_status,
  output logic [rlseq_pkg::LINK_W-1:0]      out_link_state,
  output logic [rlseq_pkg::EV_W-1:0]        out_event_kind,
  output logic [rlseq_pkg::PEER_W-1:0]      out_event_peer,
  output logic [rlseq_pkg::EVLEN_W-1:0]     out_event_length,
  output logic                              out_last
);

  rlseq_pkg::ctrl_cmd_t ctrl;
  rlseq_pkg::dp_stat_t  stat;

  rlseq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ctrl     (ctrl),
    .stat     (stat)
  );

  rlseq_dp #(
    .RING_DEPTH  (RING_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctrl                (ctrl),
    .stat                (stat),
    .in_cmd              (in_cmd),
    .in_controller_ready (in_controller_ready),
    .in_transmitter_busy (in_transmitter_busy),
    .in_peer_address     (in_peer_address),
    .in_send_length      (in_send_length),
    .in_irq_flags        (in_irq_flags),
    .in_received_length  (in_received_length),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_link_state      (out_link_state),
    .out_event_kind      (out_event_kind),
    .out_event_peer      (out_event_peer),
    .out_event_length    (out_event_length),
    .out_last            (out_last)
  );

endmodule

`default_nettype wire
